// ===== hw/rtl/stx_length_xor_frame_receiver_assert.svh =====
// Assertion macros for the start-byte frame receiver.
// Used by the top level only; no other dependencies.
`ifndef STX_LENGTH_XOR_FRAME_RECEIVER_ASSERT_SVH
`define STX_LENGTH_XOR_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STXR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STXR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/stxr_pkg.sv =====
// Shared types and constants for the start-byte frame receiver.
// No dependencies; imported by every module of the block.
package stxr_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned INDEX_W = 9;

	localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'h02;

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_LEN   = 2'd1,
		PH_DATA  = 2'd2,
		PH_CHECK = 2'd3
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic              overrun;
	} rx_item_t;

	typedef struct packed {
		logic              write_enable;
		logic [BYTE_W-1:0] write_index;
		logic [BYTE_W-1:0] write_data;
		logic              frame_done;
		logic              frame_error;
	} result_t;

	typedef struct packed {
		logic advance;
	} parse_ctrl_t;

endpackage

// ===== hw/rtl/stx_length_xor_frame_receiver.sv =====
// Start-byte / length / XOR-check frame receiver, top level.
// Depends on stxr_pkg, stxr_parser and stx_length_xor_frame_receiver_assert.svh.
//
// Bytes from a serial receiver arrive on the byte channel (byte_valid,
// byte_stall, byte_item); each transfer yields exactly one result on the
// result channel (result_valid, result_stall, result_item). A result carries
// a buffer write (length byte at index 0, payload bytes from index 1) or a
// frame done / frame error flag on the check byte; otherwise it is all zero.
// The start byte is set through cfg_write_en and cfg_write_data, and should
// only be changed while no transfer is in flight.
// A byte taken is registered in the input stage, parsed, and its result is
// registered in the result register. Throughput is one byte per cycle while
// result_stall is low, set by the single parser state update.
// When result_stall is held the result register keeps its value, the input
// stage fills, and byte_stall rises only once both stages are occupied.
// Reset clears both stages, returns the parser to the hunt and sets the start
// byte to 8'h02.
module stx_length_xor_frame_receiver (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        byte_valid,
	output logic                        byte_stall,
	input  stxr_pkg::rx_item_t          byte_item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output stxr_pkg::result_t           result_item,
	input  logic                        cfg_write_en,
	input  logic [stxr_pkg::BYTE_W-1:0] cfg_write_data
);
	import stxr_pkg::*;

	`include "stx_length_xor_frame_receiver_assert.svh"

	logic              start_byte_q;
	logic [BYTE_W-1:0] start_byte_value_q;
	rx_item_t          byte_item_s1;
	logic              byte_valid_s1;
	result_t           result_s2;
	logic              result_valid_s2;
	result_t           parse_result;
	parse_ctrl_t       ctrl;
	logic              s2_ready;
	logic              byte_accept;

	assign s2_ready     = !result_valid_s2 || !result_stall;
	assign ctrl.advance = byte_valid_s1 && s2_ready;
	assign byte_stall   = byte_valid_s1 && !s2_ready;
	assign byte_accept  = byte_valid && !byte_stall;

	assign result_valid = result_valid_s2;
	assign result_item  = result_s2;

	// Configuration register; start_byte_q marks that a write has happened.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q       <= 1'b0;
			start_byte_value_q <= START_BYTE_RESET;
		end else if (cfg_write_en) begin
			start_byte_q       <= 1'b1;
			start_byte_value_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (byte_accept) begin
			byte_valid_s1 <= 1'b1;
		end else if (ctrl.advance) begin
			byte_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_accept) begin
			byte_item_s1 <= byte_item;
		end
	end

	stxr_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.item       (byte_item_s1),
		.start_byte (start_byte_value_q),
		.result     (parse_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			result_valid_s2 <= byte_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			result_s2 <= parse_result;
		end
	end

	`STXR_ASSERT_NOW(a_done_error_excl, clk, arst_n, result_valid_s2,
		!(result_s2.frame_done && result_s2.frame_error), "done and error together")

	`STXR_ASSERT_NOW(a_idle_fields_zero, clk, arst_n,
		result_valid_s2 && !result_s2.write_enable,
		result_s2.write_index == '0 && result_s2.write_data == '0,
		"non-write result carries data")

	`STXR_ASSERT_NOW(a_stall_only_full, clk, arst_n, byte_stall,
		byte_valid_s1 && result_valid_s2 && result_stall, "stall with a free stage")

	`STXR_ASSERT_NEXT(a_cfg_taken, clk, arst_n, cfg_write_en,
		start_byte_q && start_byte_value_q == $past(cfg_write_data),
		"start byte write lost")

endmodule

// ===== hw/rtl/stxr_parser.sv =====
// Frame parser: phase, index, length and running XOR, plus the result logic.
// Depends on stxr_pkg.
module stxr_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stxr_pkg::parse_ctrl_t         ctrl,
	input  stxr_pkg::rx_item_t            item,
	input  logic [stxr_pkg::BYTE_W-1:0]   start_byte,
	output stxr_pkg::result_t             result
);
	import stxr_pkg::*;

	phase_t              phase_q, phase_d;
	logic [INDEX_W-1:0]  index_q, index_d;
	logic [BYTE_W-1:0]   length_q, length_d;
	logic [BYTE_W-1:0]   xor_q, xor_d;
	logic [BYTE_W-1:0]   xor_next;

	assign xor_next = xor_q ^ item.rx_byte;

	always_comb begin
		phase_d  = phase_q;
		index_d  = index_q;
		length_d = length_q;
		xor_d    = xor_q;
		result   = '0;
		// An overrun byte is dropped and leaves the parser untouched.
		if (!item.overrun) begin
			case (phase_q)
				PH_HUNT: begin
					if (item.rx_byte == start_byte) begin
						index_d = '0;
						xor_d   = '0;
						phase_d = PH_LEN;
					end
				end
				PH_LEN: begin
					result.write_enable = 1'b1;
					result.write_data   = item.rx_byte;
					length_d = item.rx_byte;
					xor_d    = item.rx_byte;
					index_d  = INDEX_W'(1);
					phase_d  = (item.rx_byte == '0) ? PH_CHECK : PH_DATA;
				end
				PH_DATA: begin
					result.write_enable = 1'b1;
					result.write_index  = index_q[BYTE_W-1:0];
					result.write_data   = item.rx_byte;
					xor_d   = xor_next;
					if (index_q >= {1'b0, length_q}) begin
						phase_d = PH_CHECK;
					end
					index_d = index_q + INDEX_W'(1);
				end
				PH_CHECK: begin
					xor_d = xor_next;
					result.frame_done  = (xor_next == '0);
					result.frame_error = (xor_next != '0);
					phase_d = PH_HUNT;
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			index_q  <= '0;
			length_q <= '0;
			xor_q    <= '0;
		end else if (ctrl.advance) begin
			phase_q  <= phase_d;
			index_q  <= index_d;
			length_q <= length_d;
			xor_q    <= xor_d;
		end
	end

endmodule
